/* hdl/sstd_pkg.sv */
// ----------------------------------------------------------------------------
// sstd_pkg: shared types and constants for the sample standard deviation core
// Widths follow from the set size; the serial finishing units size their
// shift registers and step counters from the same constants.
// ----------------------------------------------------------------------------
package sstd_pkg;

    localparam int NUM_SAMPLES = 16;                // samples per set, 2..256

    localparam int SAMPLE_W = 16;
    localparam int STD_W    = 24;
    localparam int FRAC_SH  = 16;                   // 8 fraction bits, squared

    localparam int N_LOG    = $clog2(NUM_SAMPLES);
    localparam int CNT_W    = N_LOG;
    localparam int N_W      = $clog2(NUM_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_W + N_LOG;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int SUMSQ_W  = SQ_W + N_LOG;
    localparam int NUM_W    = 2 * SUM_W - 1;
    localparam int QW       = NUM_W + FRAC_SH;
    localparam int STEP_W   = $clog2(QW);
    localparam int DEN      = NUM_SAMPLES * (NUM_SAMPLES - 1);
    localparam int DEN_W    = $clog2(DEN + 1);
    localparam int ROOT_W   = (QW + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int RSTEP_W  = $clog2(ROOT_W);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SAMPLES - 1);
    localparam logic [SUM_W-1:0] N_TOP    = SUM_W'(NUM_SAMPLES) << (SUM_W - N_W);
    localparam logic [DEN_W:0]   DEN_X    = (DEN_W + 1)'(DEN);

    // Completed set handed from the accumulator to the finishing sequencer
    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   sum;      // two's complement
        logic [SUMSQ_W-1:0] sumsq;
    } set_t;

    // Radicand handed from the sequencer to the root unit
    typedef struct packed {
        logic          start;
        logic [QW-1:0] radicand;
    } root_req_t;

endpackage

/* hdl/sstd_accum.sv */
// ----------------------------------------------------------------------------
// sstd_accum: sample accumulator
// Square each sample in a short pipeline, add into the running sums and
// hold a finished set until the sequencer takes it.
// ----------------------------------------------------------------------------
module sstd_accum
    import sstd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                sample_valid,
    output logic                sample_ready,
    output set_t                set_out,
    input  logic                set_take
);

    logic [CNT_W-1:0]    count_reg;
    logic [SAMPLE_W-1:0] s1_reg;
    logic                v1_reg, l1_reg;
    logic [SAMPLE_W-1:0] s2_reg;
    logic [SQ_W-1:0]     sq2_reg;
    logic                v2_reg, l2_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic                set_valid_reg;
    logic [SUM_W-1:0]    set_sum_reg;
    logic [SUMSQ_W-1:0]  set_sumsq_reg;

    logic                last_in;
    logic                accept;
    logic [SAMPLE_W-1:0] mag1;
    logic [2*SAMPLE_W-1:0] square1;
    logic [SUM_W-1:0]    sum_next;
    logic [SUMSQ_W-1:0]  sumsq_next;

    assign last_in = (count_reg == CNT_LAST);
    // Hold the closing sample while another finished set is pending
    assign sample_ready = !(last_in && (set_valid_reg || (v1_reg && l1_reg)
                                        || (v2_reg && l2_reg)));
    assign accept = sample_valid && sample_ready;

    assign mag1    = s1_reg[SAMPLE_W-1] ? (~s1_reg + 1'b1) : s1_reg;
    assign square1 = mag1 * mag1;

    assign sum_next   = sum_reg + {{N_LOG{s2_reg[SAMPLE_W-1]}}, s2_reg};
    assign sumsq_next = sumsq_reg + {{N_LOG{1'b0}}, sq2_reg};

    assign set_out.valid = set_valid_reg;
    assign set_out.sum   = set_sum_reg;
    assign set_out.sumsq = set_sumsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            set_valid_reg <= 1'b0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            sq2_reg       <= '0;
            set_sum_reg   <= '0;
            set_sumsq_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= last_in ? '0 : count_reg + 1'b1;
            end
            v1_reg <= accept;
            l1_reg <= accept && last_in;
            s1_reg <= sample;

            v2_reg  <= v1_reg;
            l2_reg  <= v1_reg && l1_reg;
            s2_reg  <= s1_reg;
            sq2_reg <= square1[SQ_W-1:0];

            if (v2_reg)
            begin
                if (l2_reg)
                begin
                    // Close the set: snapshot and clear for the next one
                    set_sum_reg   <= sum_next;
                    set_sumsq_reg <= sumsq_next;
                    sum_reg       <= '0;
                    sumsq_reg     <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    sumsq_reg <= sumsq_next;
                end
            end

            if (v2_reg && l2_reg)
            begin
                set_valid_reg <= 1'b1;
            end
            else if (set_take)
            begin
                set_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/sstd_finish.sv */
// ----------------------------------------------------------------------------
// sstd_finish: variance sequencer
// Bit-serial multiplies for sum^2 and N*sumsq, then a restoring bit-serial
// divide of the scaled numerator by N*(N-1).
// ----------------------------------------------------------------------------
module sstd_finish
    import sstd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  set_t      set_in,
    output logic      set_take,
    output root_req_t root_req,
    input  logic      root_idle
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_PROD,
        F_DIV,
        F_HAND
    } fin_state_t;

    fin_state_t          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W-1:0]    sum_mag_reg;
    logic [SUMSQ_W-1:0]  sumsq_reg;
    logic [SUM_W-1:0]    mult_reg;
    logic [NUM_W-1:0]    acc_reg;
    logic [NUM_W-1:0]    sq_reg;
    logic [QW-1:0]       div_reg;
    logic [DEN_W-1:0]    rem_reg;

    logic [SUM_W-1:0]    in_mag;
    logic [NUM_W-1:0]    addend;
    logic [NUM_W-1:0]    acc_next;
    logic [NUM_W-1:0]    num_diff;
    logic [NUM_W-1:0]    num;
    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      trial_sub;
    logic                qbit;

    assign set_take = (state_reg == F_IDLE) && set_in.valid;
    assign in_mag   = set_in.sum[SUM_W-1] ? (~set_in.sum + 1'b1) : set_in.sum;

    // MSB-first shift-add multiply step
    assign addend   = (state_reg == F_SQ) ? {{(NUM_W - SUM_W){1'b0}}, sum_mag_reg}
                                          : {{(NUM_W - SUMSQ_W){1'b0}}, sumsq_reg};
    assign acc_next = {acc_reg[NUM_W-2:0], 1'b0} + (mult_reg[SUM_W-1] ? addend : '0);

    assign num_diff = acc_next - sq_reg;
    assign num      = (acc_next >= sq_reg) ? num_diff : '0;

    // Restoring divide step
    assign trial     = {rem_reg, div_reg[QW-1]};
    assign trial_sub = trial - DEN_X;
    assign qbit      = (trial >= DEN_X);

    assign root_req.start    = (state_reg == F_HAND) && root_idle;
    assign root_req.radicand = div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            step_reg    <= '0;
            sum_mag_reg <= '0;
            sumsq_reg   <= '0;
            mult_reg    <= '0;
            acc_reg     <= '0;
            sq_reg      <= '0;
            div_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (set_in.valid)
                    begin
                        sum_mag_reg <= in_mag;
                        sumsq_reg   <= set_in.sumsq;
                        mult_reg    <= in_mag;
                        acc_reg     <= '0;
                        step_reg    <= '0;
                        state_reg   <= F_SQ;
                    end
                end
                F_SQ:
                begin
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        sq_reg    <= acc_next;
                        acc_reg   <= '0;
                        mult_reg  <= N_TOP;
                        step_reg  <= '0;
                        state_reg <= F_PROD;
                    end
                    else
                    begin
                        mult_reg <= {mult_reg[SUM_W-2:0], 1'b0};
                        step_reg <= step_reg + 1'b1;
                        acc_reg  <= acc_next;
                    end
                end
                F_PROD:
                begin
                    if (step_reg == STEP_W'(N_W - 1))
                    begin
                        div_reg   <= {num, {FRAC_SH{1'b0}}};
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= F_DIV;
                    end
                    else
                    begin
                        mult_reg <= {mult_reg[SUM_W-2:0], 1'b0};
                        step_reg <= step_reg + 1'b1;
                        acc_reg  <= acc_next;
                    end
                end
                F_DIV:
                begin
                    rem_reg  <= qbit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                    div_reg  <= {div_reg[QW-2:0], qbit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(QW - 1))
                    begin
                        state_reg <= F_HAND;
                    end
                end
                F_HAND:
                begin
                    if (root_idle)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/sstd_isqrt.sv */
// ----------------------------------------------------------------------------
// sstd_isqrt: serial integer square root
// Digit-by-digit root, two radicand bits per cycle; hold the root until
// the output register takes it.
// ----------------------------------------------------------------------------
module sstd_isqrt
    import sstd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  root_req_t         root_req,
    output logic              root_idle,
    output logic              root_valid,
    output logic [ROOT_W-1:0] root,
    input  logic              root_take
);

    typedef enum logic [1:0] {
        R_IDLE,
        R_RUN,
        R_DONE
    } root_state_t;

    root_state_t         state_reg;
    logic [RSTEP_W-1:0]  step_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic                rbit;

    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign rbit   = (rem_sh >= trial);

    assign root_idle  = (state_reg == R_IDLE);
    assign root_valid = (state_reg == R_DONE);
    assign root       = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            step_reg  <= '0;
            rad_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                R_IDLE:
                begin
                    if (root_req.start)
                    begin
                        rad_reg   <= RAD_W'(root_req.radicand);
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= R_RUN;
                    end
                end
                R_RUN:
                begin
                    rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                    rem_reg  <= rbit ? (rem_sh - trial) : rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], rbit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == RSTEP_W'(ROOT_W - 1))
                    begin
                        state_reg <= R_DONE;
                    end
                end
                R_DONE:
                begin
                    if (root_take)
                    begin
                        state_reg <= R_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/sample_std_deviation_core.sv */
// ----------------------------------------------------------------------------
// sample_std_deviation_core: sample standard deviation over fixed-size sets
// Takes NUM_SAMPLES signed 16-bit samples per set and returns one unsigned
// Q16.8 standard deviation (N-1 divisor) per set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (sample, sample_valid, sample_ready): one sample per
//   transaction. Samples stream in at one per cycle; only the closing
//   sample of a set waits while the previous set is still queued for the
//   sequencer.
//   Output channel (std_dev, std_dev_valid, std_dev_ready): one transaction
//   per completed set, in set order.
//   From the closing sample to std_dev_valid, the set passes through the
//   accumulator pipeline, the serial multiplies, the one-bit-per-cycle
//   divide, the two-bit-per-cycle root and the output register.
//   The finishing chain overlaps with the next set: the accumulator
//   collects the next set while the sequencer and the root unit finish
//   earlier ones, so the set rate is bounded by the longer of the set's
//   sample stream and the sequencer's serial multiplies and divide.
//   Reset clears the running count and sums and drops any set in flight.
//   When the receiver stalls, the result holds in the output register, the
//   root unit holds the next one, and input backs up only at set ends.
// ----------------------------------------------------------------------------
module sample_std_deviation_core
    import sstd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                sample_valid,
    output logic                sample_ready,
    output logic [STD_W-1:0]    std_dev,
    output logic                std_dev_valid,
    input  logic                std_dev_ready
);

    set_t              set_bus;
    logic              set_take;
    root_req_t         root_req;
    logic              root_idle;
    logic              root_valid;
    logic [ROOT_W-1:0] root;
    logic              root_take;

    logic              out_valid_reg;
    logic [STD_W-1:0]  out_data_reg;

    // Accumulate running sums per set
    sstd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .set_out      (set_bus),
        .set_take     (set_take)
    );

    // Form the scaled variance serially
    sstd_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_in    (set_bus),
        .set_take  (set_take),
        .root_req  (root_req),
        .root_idle (root_idle)
    );

    // Take the integer root serially
    sstd_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_req   (root_req),
        .root_idle  (root_idle),
        .root_valid (root_valid),
        .root       (root),
        .root_take  (root_take)
    );

    // Load the output register when it is empty or being drained
    assign root_take = root_valid && (!out_valid_reg || std_dev_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (root_take)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= root[STD_W-1:0];
            end
            else if (std_dev_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign std_dev_valid = out_valid_reg;
    assign std_dev       = out_data_reg;

endmodule
